// ===== src/jse_pkg.sv =====
// Shared types, constants and helper functions for the JSON string escaper.
`default_nettype none

package jse_pkg;

    // Queue between the classifier and the character expander.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Segment kinds: one plain character, a two-character escape, or \uXXXX.
    localparam logic [1:0] SEG_RAW  = 2'd0;
    localparam logic [1:0] SEG_PAIR = 2'd1;
    localparam logic [1:0] SEG_U4   = 2'd2;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] CTRL_MAX = 8'h1F;
    localparam logic [7:0] HIGH_MIN = 8'h80;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] val;
    } t_seg;

    // One queue entry holds every segment caused by one input byte.
    typedef struct packed {
        t_seg [2:0]  segs;
        logic [1:0]  nseg;
        logic        last;
    } t_entry;

    function automatic logic f_is_cont(input logic [7:0] b);
        return (b & 8'hC0) == 8'h80;
    endfunction

    function automatic logic f_is_lead2(input logic [7:0] b);
        return (b & 8'hE0) == 8'hC0;
    endfunction

    function automatic logic f_is_lead3(input logic [7:0] b);
        return (b & 8'hF0) == 8'hE0;
    endfunction

    function automatic t_seg f_u4(input logic [15:0] v);
        t_seg s;
        s.kind = SEG_U4;
        s.val  = v;
        return s;
    endfunction

    function automatic t_seg f_pair(input logic [7:0] ch);
        t_seg s;
        s.kind = SEG_PAIR;
        s.val  = {8'h00, ch};
        return s;
    endfunction

    // Segment for a byte handled with nothing held (a byte that would be
    // held is classified by the caller before this is used).
    function automatic t_seg f_fresh(input logic [7:0] b);
        t_seg s;
        s.kind = SEG_RAW;
        s.val  = {8'h00, b};
        case (b)
            CH_QUOTE:  s = f_pair(CH_QUOTE);
            CH_BSLASH: s = f_pair(CH_BSLASH);
            BYTE_BS:   s = f_pair(CH_B);
            BYTE_FF:   s = f_pair(CH_F);
            BYTE_LF:   s = f_pair(CH_N);
            BYTE_CR:   s = f_pair(CH_R);
            BYTE_TAB:  s = f_pair(CH_T);
            default: begin
                if (b <= CTRL_MAX || b >= HIGH_MIN) begin
                    s = f_u4({8'h00, b});
                end
            end
        endcase
        return s;
    endfunction

    function automatic logic [2:0] f_seg_len(input logic [1:0] kind);
        logic [2:0] n;
        case (kind)
            SEG_RAW:  n = 3'd1;
            SEG_PAIR: n = 3'd2;
            default:  n = 3'd6;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] f_hex(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'h0, n};
        end else begin
            c = 8'h61 + {4'h0, n} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/jse_in_if.sv =====
// Input channel: one string byte per transaction with its end-of-string flag.
`default_nettype none

interface jse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

// ===== src/jse_out_if.sv =====
// Output channel: one escaped character per transaction with its run flags.
`default_nettype none

interface jse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       string_done;

    modport source (output valid, output out_char, output last_of_run,
                    output string_done, input ready);
    modport sink   (input valid, input out_char, input last_of_run,
                    input string_done, output ready);
endinterface

`default_nettype wire

// ===== src/jse_front.sv =====
// Classifier: tracks held UTF-8 bytes and turns each byte into escape segments.
`default_nettype none

module jse_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eos,
    output jse_pkg::t_entry      o_entry,
    output logic                 o_push
);

    logic [7:0] r_lead, n_lead;
    logic [7:0] r_second, n_second;
    logic [1:0] r_count, n_count;
    jse_pkg::t_entry entry;
    logic            has_out;
    logic            hold_b;

    assign hold_b = (jse_pkg::f_is_lead2(i_byte) || jse_pkg::f_is_lead3(i_byte)) && !i_eos;

    always_comb begin
        entry      = '0;
        entry.last = i_eos;
        has_out    = 1'b1;
        n_lead     = r_lead;
        n_second   = r_second;
        n_count    = 2'd0;
        case (r_count)
            2'd1: begin
                if (jse_pkg::f_is_lead2(r_lead) && jse_pkg::f_is_cont(i_byte)) begin
                    entry.segs[0] = jse_pkg::f_u4({5'd0, r_lead[4:0], i_byte[5:0]});
                    entry.nseg    = 2'd1;
                end else if (jse_pkg::f_is_lead3(r_lead) && jse_pkg::f_is_cont(i_byte)
                             && !i_eos) begin
                    has_out  = 1'b0;
                    n_second = i_byte;
                    n_count  = 2'd2;
                end else begin
                    entry.segs[0] = jse_pkg::f_u4({8'h00, r_lead});
                    if (hold_b) begin
                        entry.nseg = 2'd1;
                        n_lead     = i_byte;
                        n_count    = 2'd1;
                    end else begin
                        entry.segs[1] = jse_pkg::f_fresh(i_byte);
                        entry.nseg    = 2'd2;
                    end
                end
            end
            2'd2: begin
                if (jse_pkg::f_is_cont(i_byte)) begin
                    entry.segs[0] = jse_pkg::f_u4({r_lead[3:0], r_second[5:0], i_byte[5:0]});
                    entry.nseg    = 2'd1;
                end else begin
                    // Broken three-byte sequence: both held bytes go out as \u escapes.
                    entry.segs[0] = jse_pkg::f_u4({8'h00, r_lead});
                    entry.segs[1] = jse_pkg::f_fresh(r_second);
                    if (hold_b) begin
                        entry.nseg = 2'd2;
                        n_lead     = i_byte;
                        n_count    = 2'd1;
                    end else begin
                        entry.segs[2] = jse_pkg::f_fresh(i_byte);
                        entry.nseg    = 2'd3;
                    end
                end
            end
            default: begin
                if (hold_b) begin
                    has_out = 1'b0;
                    n_lead  = i_byte;
                    n_count = 2'd1;
                end else begin
                    entry.segs[0] = jse_pkg::f_fresh(i_byte);
                    entry.nseg    = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= 8'h00;
            r_second <= 8'h00;
            r_count  <= 2'd0;
        end else if (i_accept) begin
            r_lead   <= n_lead;
            r_second <= n_second;
            r_count  <= n_count;
        end
    end

    assign o_entry = entry;
    assign o_push  = i_accept && has_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("held byte count out of range");

endmodule

`default_nettype wire

// ===== src/jse_queue.sv =====
// Short queue of segment entries between the classifier and the expander.
`default_nettype none

module jse_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire jse_pkg::t_entry i_entry,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_valid,
    output jse_pkg::t_entry      o_head
);

    jse_pkg::t_entry r_mem [jse_pkg::QDEPTH];
    logic [jse_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [jse_pkg::QCNT_W-1:0] r_cnt;
    logic                       do_pop;

    assign o_full  = r_cnt == jse_pkg::QCNT_W'(jse_pkg::QDEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || do_pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ===== src/jse_back.sv =====
// Expander: walks the head entry's segments; one character a cycle unless stalled.
`default_nettype none

module jse_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire jse_pkg::t_entry i_head,
    output logic                 o_pop,
    jse_out_if.source            o_out
);

    logic [1:0] r_seg;
    logic [2:0] r_chr;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_lor;
    logic       r_done;

    jse_pkg::t_seg seg;
    logic [7:0]    ch;
    logic          seg_end;
    logic          entry_end;
    logic          load;

    assign seg       = i_head.segs[r_seg];
    assign seg_end   = r_chr == (jse_pkg::f_seg_len(seg.kind) - 3'd1);
    assign entry_end = seg_end && (r_seg == (i_head.nseg - 2'd1));
    assign load      = !r_valid || o_out.ready;
    assign o_pop     = load && i_valid && entry_end;

    always_comb begin
        case (seg.kind)
            jse_pkg::SEG_RAW: ch = seg.val[7:0];
            jse_pkg::SEG_PAIR: ch = (r_chr == 3'd0) ? jse_pkg::CH_BSLASH : seg.val[7:0];
            default: begin
                case (r_chr)
                    3'd0:    ch = jse_pkg::CH_BSLASH;
                    3'd1:    ch = jse_pkg::CH_U;
                    3'd2:    ch = jse_pkg::f_hex(seg.val[15:12]);
                    3'd3:    ch = jse_pkg::f_hex(seg.val[11:8]);
                    3'd4:    ch = jse_pkg::f_hex(seg.val[7:4]);
                    default: ch = jse_pkg::f_hex(seg.val[3:0]);
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seg   <= 2'd0;
            r_chr   <= 3'd0;
        end else if (load) begin
            r_valid <= i_valid;
            if (i_valid) begin
                if (entry_end) begin
                    r_seg <= 2'd0;
                    r_chr <= 3'd0;
                end else if (seg_end) begin
                    r_seg <= r_seg + 2'd1;
                    r_chr <= 3'd0;
                end else begin
                    r_chr <= r_chr + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_char <= ch;
            r_lor  <= entry_end;
            r_done <= entry_end && i_head.last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_char    = r_char;
    assign o_out.last_of_run = r_lor;
    assign o_out.string_done = r_done;

    a_chr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chr < 3'd6 && r_seg < 2'd3)
        else $error("expander position out of range");

    a_done_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_done |-> r_lor)
        else $error("string end flagged inside a run");

endmodule

`default_nettype wire

// ===== src/json_string_escaper.sv =====
// Top level of the streaming JSON string escaper.
// Throughput: one output character per cycle while the sink is ready, set by the
// expander's output register; input bytes are taken one per cycle while the four-entry
// queue has room. A byte expands to at most eighteen characters, so escapes throttle
// the input side. Escapes are registered in the queue, then in the output register.
// Reset (synchronous, active low) clears held UTF-8 bytes, the queue and output valid.
`default_nettype none

module json_string_escaper (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    jse_in_if.sink    i_in,
    jse_out_if.source o_out
);

    // The front classifies each accepted byte into up to three segments
    // (a plain character, a two-character escape or a \uXXXX group) and
    // keeps the held lead and second bytes of an unfinished UTF-8 sequence.
    // A byte that only adds to the held sequence produces no queue entry.
    jse_pkg::t_entry push_entry;
    logic            push;
    logic            full;
    logic            accept;

    // The back pops whole entries once their last character has been
    // loaded into the output register.
    jse_pkg::t_entry head;
    logic            head_valid;
    logic            pop;

    // The input is taken whenever the queue has a free slot, independent of
    // whether the downstream side is stalled.
    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    jse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_eos    (i_in.end_of_string),
        .o_entry  (push_entry),
        .o_push   (push)
    );

    jse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    jse_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
